### rtl/modular_exponentiation_macros.svh
// Assertion macros used by the sequencer of the modular exponentiation RTL.
// Each macro expects i_clk and i_rst_n to be visible at the point of use.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mexp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mexp: next-cycle check failed");

`endif

### rtl/mexp_pkg.sv
// Package for the modular exponentiation block: widths and the command and
// status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int OPERAND_WIDTH  = 32;
    localparam int EXPONENT_WIDTH = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int SUM_WIDTH      = OPERAND_WIDTH + 2;
    localparam int STEP_WIDTH     = $clog2(OPERAND_WIDTH);
    localparam int BIT_WIDTH      = $clog2(EXPONENT_WIDTH);

    typedef struct packed {
        logic load;       // capture a new transaction and the modulus
        logic step;       // one shift-and-add step of the modular multiplier
        logic reduce;     // step adds the next bit instead of the multiplicand
        logic start;      // clear the multiplier and load its operands
        logic sel_sqr;    // operands are base and base, otherwise product and base
        logic wb_base;    // multiplier result goes to the base register
        logic wb_acc;     // multiplier result goes to the running product
        logic exp_shift;  // move to the next exponent bit
        logic out_load;   // move the finished result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic exp_lsb;    // current exponent bit
        logic out_free;   // output register can take a result this cycle
    } t_dp_stat;

endpackage

### rtl/mexp_in_if.sv
// Input channel of the modular exponentiation block: valid, ready, payload.
// Depends on mexp_pkg for the field width.
`timescale 1ns / 1ps

interface mexp_in_if
    import mexp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] base_value;
    logic [FIELD_WIDTH-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

### rtl/mexp_out_if.sv
// Output channel of the modular exponentiation block: valid, ready, payload.
// Depends on mexp_pkg for the field width.
`timescale 1ns / 1ps

interface mexp_out_if
    import mexp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

### rtl/modular_exponentiation.sv
// One transaction at a time; the multiplier takes one cycle per bit.
// A new transaction is accepted while the previous result still waits in the output register.
// Reset (synchronous, active low) clears the controller and output valid; modulus returns to 1.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if, mexp_ctrl and mexp_datapath.
`timescale 1ns / 1ps

module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [FIELD_WIDTH-1:0] i_cfg_wr_data,
    mexp_in_if.sink                i_in,
    mexp_out_if.source             o_out
);

    // The controller sequences the work of one transaction. It first reduces
    // the base modulo the modulus by running the multiplier in a mode that
    // shifts in base bits, one per cycle. It then visits every exponent bit,
    // least significant first: a set bit multiplies the running product by
    // the base, and every bit squares the base. Each modular multiply takes
    // one step per operand bit, OPERAND_WIDTH in all, and then writes its result back.

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // The datapath holds the modulus register, the operands and the output
    // register. A zero exponent yields 1 whatever the modulus; otherwise the
    // running product starts at 1 reduced modulo the modulus.
    mexp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_base_value   (i_in.base_value),
        .i_exponent     (i_in.exponent),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_power_result (o_out.power_result)
    );

endmodule

### rtl/mexp_ctrl.sv
// Sequencer of the modular exponentiation block: walks reduction, multiply
// and square passes. Depends on mexp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "modular_exponentiation_macros.svh"

module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RED    = 4'd1;
    localparam logic [3:0] S_RED_WB = 4'd2;
    localparam logic [3:0] S_PICK   = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_MUL_WB = 4'd5;
    localparam logic [3:0] S_SQR    = 4'd6;
    localparam logic [3:0] S_SQR_WB = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(OPERAND_WIDTH - 1);
    localparam logic [BIT_WIDTH-1:0]  BIT_LAST  = BIT_WIDTH'(EXPONENT_WIDTH - 1);

    logic [3:0]            r_state, n_state;
    logic [STEP_WIDTH-1:0] r_step, n_step;
    logic [BIT_WIDTH-1:0]  r_bit, n_bit;
    logic                  w_step_last;
    logic                  w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_step_last = (r_step == STEP_LAST);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_bit   = r_bit;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_bit      = '0;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                o_cmd.step   = 1'b1;
                o_cmd.reduce = 1'b1;
                n_step       = w_step_last ? '0 : r_step + 1'b1;
                if (w_step_last) begin
                    n_state = S_RED_WB;
                end
            end
            S_RED_WB: begin
                o_cmd.wb_base = 1'b1;
                n_state       = S_PICK;
            end
            S_PICK: begin
                o_cmd.start   = 1'b1;
                o_cmd.sel_sqr = !i_stat.exp_lsb;
                n_state       = i_stat.exp_lsb ? S_MUL : S_SQR;
            end
            S_MUL: begin
                o_cmd.step = 1'b1;
                n_step     = w_step_last ? '0 : r_step + 1'b1;
                if (w_step_last) begin
                    n_state = S_MUL_WB;
                end
            end
            S_MUL_WB: begin
                o_cmd.wb_acc  = 1'b1;
                o_cmd.start   = 1'b1;
                o_cmd.sel_sqr = 1'b1;
                n_state       = S_SQR;
            end
            S_SQR: begin
                o_cmd.step = 1'b1;
                n_step     = w_step_last ? '0 : r_step + 1'b1;
                if (w_step_last) begin
                    n_state = S_SQR_WB;
                end
            end
            S_SQR_WB: begin
                o_cmd.wb_base   = 1'b1;
                o_cmd.exp_shift = 1'b1;
                if (r_bit == BIT_LAST) begin
                    n_state = S_FINISH;
                end else begin
                    n_bit   = r_bit + 1'b1;
                    n_state = S_PICK;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_bit   <= n_bit;
        end
    end

    `MEXP_ASSERT_SAME(a_out_load_free, o_cmd.out_load, i_stat.out_free)
    `MEXP_ASSERT_NEXT(a_accept_to_reduce, w_accept, r_state == S_RED)
    `MEXP_ASSERT_NEXT(a_pick_step_clear, r_state == S_PICK, r_step == '0)
    `MEXP_ASSERT_NEXT(a_last_bit_finish, (r_state == S_SQR_WB) && (r_bit == BIT_LAST),
                      r_state == S_FINISH)

endmodule

### rtl/mexp_datapath.sv
// Datapath of the modular exponentiation block: modulus register, interleaved
// shift-and-add modular multiplier, operand registers and output register.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_datapath
    import mexp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [FIELD_WIDTH-1:0] i_cfg_wr_data,
    input  logic [FIELD_WIDTH-1:0] i_base_value,
    input  logic [FIELD_WIDTH-1:0] i_exponent,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [FIELD_WIDTH-1:0] o_power_result
);

    logic [FIELD_WIDTH-1:0]    r_modulus;
    logic [OPERAND_WIDTH-1:0]  r_m;
    logic [OPERAND_WIDTH-1:0]  r_ma;
    logic [OPERAND_WIDTH-1:0]  r_mb;
    logic [OPERAND_WIDTH-1:0]  r_prod, n_prod;
    logic [OPERAND_WIDTH-1:0]  r_base;
    logic [OPERAND_WIDTH-1:0]  r_acc;
    logic [EXPONENT_WIDTH-1:0] r_exp;
    logic                      r_ezero;
    logic [FIELD_WIDTH-1:0]    r_result;
    logic                      r_out_valid, n_out_valid;

    logic [OPERAND_WIDTH-1:0]  w_mod_eff;
    logic [EXPONENT_WIDTH-1:0] w_exp_in;
    logic [SUM_WIDTH-1:0]      w_addend;
    logic [SUM_WIDTH-1:0]      w_sum;
    logic [SUM_WIDTH-1:0]      w_m1;
    logic [SUM_WIDTH-1:0]      w_m2;

    // A modulus of zero after masking behaves as a modulus of one.
    assign w_mod_eff = (OPERAND_WIDTH'(r_modulus) == '0) ? OPERAND_WIDTH'(1)
                                                         : OPERAND_WIDTH'(r_modulus);
    assign w_exp_in  = EXPONENT_WIDTH'(i_exponent);

    // One step: 2*prod + addend stays below three times the modulus, so one of
    // two parallel subtractions brings it back into range.
    assign w_addend = i_cmd.reduce ? SUM_WIDTH'(r_mb[OPERAND_WIDTH-1])
                    : (r_mb[OPERAND_WIDTH-1] ? SUM_WIDTH'(r_ma) : '0);
    assign w_sum    = {1'b0, r_prod, 1'b0} + w_addend;
    assign w_m1     = SUM_WIDTH'(r_m);
    assign w_m2     = {1'b0, r_m, 1'b0};

    always_comb begin
        if (w_sum >= w_m2) begin
            n_prod = OPERAND_WIDTH'(w_sum - w_m2);
        end else if (w_sum >= w_m1) begin
            n_prod = OPERAND_WIDTH'(w_sum - w_m1);
        end else begin
            n_prod = OPERAND_WIDTH'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= FIELD_WIDTH'(1);
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m     <= w_mod_eff;
            r_mb    <= OPERAND_WIDTH'(i_base_value);
            r_prod  <= '0;
            r_acc   <= (w_mod_eff == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
            r_exp   <= w_exp_in;
            r_ezero <= (w_exp_in == '0);
        end else begin
            if (i_cmd.start) begin
                r_ma   <= i_cmd.sel_sqr ? r_base : r_acc;
                r_mb   <= r_base;
                r_prod <= '0;
            end else if (i_cmd.step) begin
                r_mb   <= {r_mb[OPERAND_WIDTH-2:0], 1'b0};
                r_prod <= n_prod;
            end
            if (i_cmd.wb_base) begin
                r_base <= r_prod;
            end
            if (i_cmd.wb_acc) begin
                r_acc <= r_prod;
            end
            if (i_cmd.exp_shift) begin
                r_exp <= {1'b0, r_exp[EXPONENT_WIDTH-1:1]};
            end
        end
    end

    assign o_stat.exp_lsb  = r_exp[0];
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result <= r_ezero ? FIELD_WIDTH'(1) : FIELD_WIDTH'(r_acc);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_result;

endmodule
